// ===== design/bua_pkg.sv =====
// Package for the block upscaler with average fill.
// Types, constants and helpers for the controller, datapath, top level and testbench; no dependencies.
`default_nettype none
package bua_pkg;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int MAX_FACTOR_DEF = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int COORD_W    = 12;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GRAY   = 2'd3;

	typedef logic [23:0] pixel_t;

	// input beat: one source pixel
	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_beat_t;

	// output beat: one enlarged-image pixel with its coordinates
	typedef struct packed {
		logic [11:0] out_row;
		logic [11:0] out_col;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic        last_of_run;
	} up_beat_t;

	// block kinds in emission order
	typedef enum logic [1:0] {
		BLK_UPLEFT = 2'd0,
		BLK_UP     = 2'd1,
		BLK_LEFT   = 2'd2,
		BLK_SELF   = 2'd3
	} blk_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PLAN,
		ST_AVG,
		ST_EMIT,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic capture;   // latch input pixel, start line store read
		logic take_rd;   // register line store data and edge flags
		logic load_blk;  // load neighbors of next block and clear x,y
		blk_t blk;
		logic step;      // advance inside block
		logic update;    // write line store, advance counters
	} cmd_t;

	typedef struct packed {
		logic [3:0] need;   // blocks this pixel completes
		logic       blk_end;
		logic       out_busy;
	} sts_t;

	function automatic logic [7:0] mean4(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d);
		logic [9:0] s;
		s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
		return s[9:2];
	endfunction
endpackage
`default_nettype wire

// ===== design/bua_stream_if.sv =====
// Valid/ready stream interface used for input and output channels.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface bua_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/bua_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bua_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/bua_ctrl.sv =====
// Upscaler sequencer: per pixel read, plan, avg and emit per block, update.
// Depends on bua_pkg.
`default_nettype none
module bua_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire bua_pkg::sts_t sts,
	output bua_pkg::cmd_t      cmd
);
	import bua_pkg::*;
	state_t state_q, state_d;
	logic [3:0] pend_q, pend_d;
	blk_t sel;

	always_comb begin
		sel = BLK_SELF;
		if (pend_q[0]) sel = BLK_UPLEFT;
		else if (pend_q[1]) sel = BLK_UP;
		else if (pend_q[2]) sel = BLK_LEFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= '0;
		end else begin
			state_q <= state_d;
			pend_q <= pend_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pend_d = pend_q;
		cmd = '0;
		cmd.blk = sel;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.take_rd = 1'b1;
				state_d = ST_PLAN;
			end
			ST_PLAN: begin
				pend_d = sts.need;
				state_d = (sts.need == '0) ? ST_UPDATE : ST_AVG;
			end
			ST_AVG: begin
				cmd.load_blk = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.step = 1'b1;
					if (sts.blk_end) begin
						pend_d = pend_q & ~(4'b1 << sel);
						state_d = ((pend_q & ~(4'b1 << sel)) == '0) ? ST_UPDATE : ST_AVG;
					end
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_plan_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_PLAN) else $error("plan skipped");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> pend_q != '0) else $error("emit with nothing pending");
endmodule
`default_nettype wire

// ===== design/bua_dp.sv =====
// Datapath: config registers, counters, neighbor registers, line store,
// block mean and output register. Depends on bua_pkg, bua_ram.
`default_nettype none
module bua_dp #(
	parameter int MAX_WIDTH  = bua_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bua_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_FACTOR = bua_pkg::MAX_FACTOR_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bua_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [bua_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire bua_pkg::pixel_t                    in_px,
	input  wire bua_pkg::cmd_t                      cmd,
	output bua_pkg::sts_t                           sts,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [bua_pkg::COORD_W-1:0]             row_o,
	output logic [bua_pkg::COORD_W-1:0]             col_o,
	output bua_pkg::pixel_t                         px_o,
	output logic                                    last_o
);
	import bua_pkg::*;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int FW = $clog2(MAX_FACTOR + 1);
	localparam int SW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

	logic [10:0] width_q, height_q;
	logic [2:0]  factor_q;
	logic        gray_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	pixel_t cur_q, left_q, aleft_q, above_q;
	logic last_col_q, last_row_q;
	pixel_t p_q, avg_q;
	logic [CW-1:0] bc_q;
	logic [RW-1:0] br_q;
	logic [SW-1:0] x_q, y_q;
	logic [FW-1:0] f_eff;
	logic [12:0] w_eff, h_eff;
	pixel_t rd;
	logic [3:0] need_q;
	pixel_t na, nb, nc, nd;
	pixel_t px_sel;
	logic out_busy, blk_end, last_blk;

	always_comb begin
		w_eff = (width_q == '0) ? 13'd1 : ({2'b0, width_q} > 13'(MAX_WIDTH)) ?
			13'(MAX_WIDTH) : {2'b0, width_q};
		h_eff = (height_q == '0) ? 13'd1 : ({2'b0, height_q} > 13'(MAX_HEIGHT)) ?
			13'(MAX_HEIGHT) : {2'b0, height_q};
		f_eff = (factor_q == '0) ? FW'(1) : (4'(factor_q) > 4'(MAX_FACTOR)) ?
			FW'(MAX_FACTOR) : FW'(factor_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd640;
			height_q <= 11'd480;
			factor_q <= 3'd2;
			gray_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WIDTH:  width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_FACTOR: factor_q <= cfg_data[2:0];
				REG_GRAY:   gray_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bua_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_line (
		.clk(clk), .we(cmd.update), .waddr(col_q), .wdata(cur_q),
		.raddr(col_q), .rdata(rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) cur_q <= in_px;
		if (cmd.take_rd) begin
			above_q <= rd;
			last_col_q <= 13'(col_q) >= w_eff - 13'd1;
			last_row_q <= 13'(row_q) >= h_eff - 13'd1;
		end
	end

	always_comb begin
		need_q[0] = (row_q != '0) && (col_q != '0);
		need_q[1] = (row_q != '0) && last_col_q;
		need_q[2] = last_row_q && (col_q != '0);
		need_q[3] = last_row_q && last_col_q;
	end
	assign sts.need = need_q;

	always_comb begin
		na = cur_q; nb = cur_q; nc = cur_q; nd = cur_q;
		case (cmd.blk)
			BLK_UPLEFT: begin na = aleft_q; nb = above_q; nc = left_q; end
			BLK_UP:     begin na = above_q; nb = above_q; end
			BLK_LEFT:   begin na = left_q; nc = left_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			left_q <= '0;
			aleft_q <= '0;
		end else if (cmd.update) begin
			aleft_q <= above_q;
			left_q <= cur_q;
			if (last_col_q) begin
				col_q <= '0;
				row_q <= last_row_q ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// block state: neighbors, mean and position inside block
	always_ff @(posedge clk) begin
		if (cmd.load_blk) begin
			p_q <= na;
			avg_q <= {mean4(na[23:16], nb[23:16], nc[23:16], nd[23:16]),
				mean4(na[15:8], nb[15:8], nc[15:8], nd[15:8]),
				mean4(na[7:0], nb[7:0], nc[7:0], nd[7:0])};
			br_q <= (cmd.blk == BLK_UPLEFT || cmd.blk == BLK_UP) ? row_q - 1'b1 : row_q;
			bc_q <= (cmd.blk == BLK_UPLEFT || cmd.blk == BLK_LEFT) ? col_q - 1'b1 : col_q;
		end
	end

	assign blk_end = (FW'(x_q) == f_eff - 1'b1) && (FW'(y_q) == f_eff - 1'b1);
	// last block of this pixel: no higher pending bit
	assign last_blk = (need_q >> cmd.blk) == 4'd1;
	assign out_busy = out_valid && !out_ready;
	assign sts.out_busy = out_busy;
	assign sts.blk_end = blk_end;

	// top-left of the block is the pixel itself; gray mode zeroes green and blue
	assign px_sel = (x_q == '0 && y_q == '0) ? p_q : avg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.load_blk) begin
				x_q <= '0;
				y_q <= '0;
			end else if (cmd.step) begin
				out_valid <= 1'b1;
				if (FW'(x_q) == f_eff - 1'b1) begin
					x_q <= '0;
					y_q <= y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			row_o <= COORD_W'(24'(br_q) * 24'(f_eff) + 24'(y_q));
			col_o <= COORD_W'(24'(bc_q) * 24'(f_eff) + 24'(x_q));
			px_o <= gray_q ? {px_sel[23:16], 16'h0000} : px_sel;
			last_o <= blk_end && last_blk;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !cmd.step) else $error("output overwritten");
	a_pos_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> FW'(x_q) < f_eff && FW'(y_q) < f_eff) else $error("pos out of block");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(row_o) && $stable(px_o)) else $error("hold");
endmodule
`default_nettype wire

// ===== design/block_upscale_with_average_fill_unit.sv =====
// Top level of the integer-factor upscaler with average fill.
// Depends on bua_pkg, bua_stream_if, bua_ctrl, bua_dp, bua_ram.
//
//  port      dir   beat content
//  pix_in    sink  red_in, green_in, blue_in
//  pix_out   src   out_row, out_col, red_out, green_out, blue_out, last_of_run
//  cfg_*     in    we, index 0..3, 11-bit data
//
// Sequence: a pixel completing no block passes idle, read, plan, update;
// otherwise each block it completes adds a mean step (avg state), then one
// output beat per cycle from the single emit counter while the output is
// not stalled. Line store is one RAM read then one write per pixel.
// Reset clears counters and left neighbor registers and loads config defaults;
// line store is not cleared. A stalled output holds the sequencer in place.
`default_nettype none
module block_upscale_with_average_fill_unit #(
	parameter int MAX_WIDTH  = bua_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bua_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_FACTOR = bua_pkg::MAX_FACTOR_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           cfg_we,
	input wire logic [bua_pkg::CFG_IDX_W-1:0]  cfg_index,
	input wire logic [bua_pkg::CFG_DATA_W-1:0] cfg_data,
	bua_stream_if.sink                         pix_in,
	bua_stream_if.source                       pix_out
);
	import bua_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign pix_in.ready = in_ready;

	bua_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(pix_in.valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	bua_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_FACTOR(MAX_FACTOR)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
		.cfg_data(cfg_data),
		.in_px({pix_in.data.red_in, pix_in.data.green_in, pix_in.data.blue_in}),
		.cmd(cmd), .sts(sts), .out_valid(pix_out.valid), .out_ready(pix_out.ready),
		.row_o(pix_out.data.out_row), .col_o(pix_out.data.out_col),
		.px_o({pix_out.data.red_out, pix_out.data.green_out, pix_out.data.blue_out}),
		.last_o(pix_out.data.last_of_run)
	);
endmodule
`default_nettype wire

// ===== verif/tb_block_upscale_with_average_fill_unit.sv =====
// Self-checking testbench for block_upscale_with_average_fill_unit.
// Depends on bua_pkg, bua_stream_if and the block itself; drives whole frames and
// compares every output beat against an in-bench predictor of the upscaler.
`default_nettype none
module tb_block_upscale_with_average_fill_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import bua_pkg::*;

	// Predictor of the upscaler plus the queue of output beats it still owes.
	class upscale_scoreboard;
		logic [10:0] width_reg, height_reg;
		logic [2:0]  factor_reg;
		logic        gray_reg;
		pixel_t      row_above [1024];
		pixel_t      left_px, above_left_px;
		int unsigned row_cnt, col_cnt;
		up_beat_t    owed [$];
		int          errors;

		function void reset_state();
			width_reg = 11'd640;
			height_reg = 11'd480;
			factor_reg = 3'd2;
			gray_reg = 1'b0;
			foreach (row_above[i]) row_above[i] = '0;
			left_px = '0;
			above_left_px = '0;
			row_cnt = 0;
			col_cnt = 0;
			owed.delete();
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_WIDTH: width_reg = val;
				REG_HEIGHT: height_reg = val;
				REG_FACTOR: factor_reg = val[2:0];
				REG_GRAY: gray_reg = val[0];
				default: ;
			endcase
		endfunction

		static function int unsigned sat(int unsigned v, int unsigned hi);
			if (v < 1) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function void push_block(int unsigned br, int unsigned bc, int unsigned f,
			pixel_t p, pixel_t r, pixel_t d, pixel_t dr);
			pixel_t   avg, v;
			up_beat_t o;
			for (int k = 0; k < 24; k += 8)
				avg[k+:8] = 8'((10'(p[k+:8]) + r[k+:8] + d[k+:8] + dr[k+:8]) >> 2);
			for (int unsigned y = 0; y < f; y++) begin
				for (int unsigned x = 0; x < f; x++) begin
					v = (y == 0 && x == 0) ? p : avg;
					o.out_row = 12'(br * f + y);
					o.out_col = 12'(bc * f + x);
					o.red_out = v[23:16];
					o.green_out = gray_reg ? 8'd0 : v[15:8];
					o.blue_out = gray_reg ? 8'd0 : v[7:0];
					o.last_of_run = 1'b0;
					owed.push_back(o);
				end
			end
		endfunction

		// Accepted source pixel: queue the blocks it completes, then advance.
		function void note_pixel(pix_beat_t px);
			int unsigned w, h, f, slot, n0;
			logic        lc, lr;
			pixel_t      cur, above;
			w = sat(32'(width_reg), 1024);
			h = sat(32'(height_reg), 1024);
			f = sat(32'(factor_reg), 4);
			lc = (col_cnt >= w - 1);
			lr = (row_cnt >= h - 1);
			cur = {px.red_in, px.green_in, px.blue_in};
			slot = (col_cnt < 1024) ? col_cnt : 1023;
			above = row_above[slot];
			n0 = owed.size();
			if (row_cnt >= 1) begin
				if (col_cnt >= 1)
					push_block(row_cnt - 1, col_cnt - 1, f, above_left_px, above, left_px, cur);
				if (lc) push_block(row_cnt - 1, col_cnt, f, above, above, cur, cur);
			end
			if (lr) begin
				if (col_cnt >= 1) push_block(row_cnt, col_cnt - 1, f, left_px, cur, left_px, cur);
				if (lc) push_block(row_cnt, col_cnt, f, cur, cur, cur, cur);
			end
			if (owed.size() > n0) owed[owed.size()-1].last_of_run = 1'b1;
			row_above[slot] = cur;
			above_left_px = above;
			left_px = cur;
			if (lc) begin
				col_cnt = 0;
				row_cnt = lr ? 0 : row_cnt + 1;
			end else begin
				col_cnt = col_cnt + 1;
			end
		endfunction

		function void check_beat(up_beat_t got);
			up_beat_t exp_b;
			if (owed.size() == 0) begin
				$error("output beat with nothing owed: %p", got);
				errors++;
				return;
			end
			exp_b = owed.pop_front();
			if (got.out_row !== exp_b.out_row) begin
				$error("out_row exp %0d got %0d", exp_b.out_row, got.out_row); errors++;
			end
			if (got.out_col !== exp_b.out_col) begin
				$error("out_col exp %0d got %0d", exp_b.out_col, got.out_col); errors++;
			end
			if (got.red_out !== exp_b.red_out) begin
				$error("red_out exp %0d got %0d", exp_b.red_out, got.red_out); errors++;
			end
			if (got.green_out !== exp_b.green_out) begin
				$error("green_out exp %0d got %0d", exp_b.green_out, got.green_out); errors++;
			end
			if (got.blue_out !== exp_b.blue_out) begin
				$error("blue_out exp %0d got %0d", exp_b.blue_out, got.blue_out); errors++;
			end
			if (got.last_of_run !== exp_b.last_of_run) begin
				$error("last_of_run exp %0d got %0d", exp_b.last_of_run, got.last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bua_stream_if #(.T(pix_beat_t)) pix_in ();
	bua_stream_if #(.T(up_beat_t))  pix_out ();

	block_upscale_with_average_fill_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_in(pix_in), .pix_out(pix_out)
	);

	upscale_scoreboard sb;
	bit no_gaps;          // phase-wide: both sides run without idling
	bit hold_req;         // ask the sink for one long back-pressure stretch
	bit stim_done;
	longint unsigned cycles = 0;

	always #6 clk = ~clk;

	initial begin
		pix_in.valid = 1'b0;
		pix_in.data = '0;
		pix_out.ready = 1'b0;
	end

	// Hard stop: far beyond the slowest legal run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd6000000) begin
			$display("block_upscale_with_average_fill_unit verification failed");
			$finish;
		end
	end

	// Output side: random ready gaps, one long hold when requested.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pix_out.ready <= 1'b0;
				repeat (600) @(negedge clk);
				hold_req = 1'b0;
			end
			gap = no_gaps ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				pix_out.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pix_out.ready <= 1'b1;
			do @(posedge clk); while (!pix_out.valid);
			sb.check_beat(pix_out.data);
		end
	end

	// One source pixel beat; valid stays up across back-to-back beats.
	task automatic send_pixel(pix_beat_t px);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.data <= px;
		do @(posedge clk); while (!pix_in.ready);
		sb.note_pixel(px);
		@(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	function automatic pix_beat_t rand_pixel(bit extremes);
		pix_beat_t p;
		p = pix_beat_t'(24'($urandom()));
		if (extremes) begin
			p.red_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			p.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			p.blue_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return p;
	endfunction

	// Wait for the block to drain, reprogram it, then stream one whole frame.
	task automatic run_frame(int w, int h, int f, int g, bit extremes, output int pixels);
		int unsigned we, he;
		while (sb.owed.size() != 0) @(negedge clk);
		pix_in.valid <= 1'b0;
		repeat (20) @(negedge clk);
		cfg_write(REG_WIDTH, CFG_DATA_W'(w));
		cfg_write(REG_HEIGHT, CFG_DATA_W'(h));
		cfg_write(REG_FACTOR, CFG_DATA_W'(f));
		cfg_write(REG_GRAY, CFG_DATA_W'(g));
		cfg_we <= 1'b0;
		we = upscale_scoreboard::sat(w, 1024);
		he = upscale_scoreboard::sat(h, 1024);
		pixels = we * he;
		no_gaps = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < pixels; i++) send_pixel(rand_pixel(extremes));
		pix_in.valid <= 1'b0;
	endtask

	initial begin
		int n, total;
		sb = new();
		sb.reset_state();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: single pixel, saturated/zero registers, both modes, max factor.
		run_frame(1, 1, 1, 0, 1, n);
		run_frame(0, 0, 0, 1, 1, n);
		run_frame(2, 2, 4, 0, 1, n);
		run_frame(3, 2, 7, 1, 0, n);
		run_frame(4, 1, 3, 0, 1, n);
		run_frame(1, 3, 2, 1, 0, n);

		// Long output stall while the sender keeps pushing a max-factor frame.
		hold_req = 1'b1;
		run_frame(4, 4, 4, 0, 0, n);

		// Random frames, mostly small.
		total = 0;
		while (total < 370) begin
			run_frame($urandom_range(0, 9), $urandom_range(0, 6), $urandom_range(0, 7),
				$urandom_range(0, 1), $urandom_range(0, 5) == 0, n);
			total += n;
		end

		pix_in.valid <= 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("block_upscale_with_average_fill_unit verification clean");
		else
			$display("block_upscale_with_average_fill_unit verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
design/bua_pkg.sv
design/bua_stream_if.sv
design/bua_ram.sv
design/bua_ctrl.sv
design/bua_dp.sv
design/block_upscale_with_average_fill_unit.sv
verif/tb_block_upscale_with_average_fill_unit.sv
